/* rtl/metasprite_record_parser_assert.svh */
// assertion macros shared by the sprite-frame record parser rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef METASPRITE_RECORD_PARSER_ASSERT_SVH
`define METASPRITE_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, held off during reset
`define MSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msp assertion failed");

// next-cycle implication, held off during reset
`define MSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msp assertion failed");

`endif

/* rtl/msp_pkg.sv */
// types and constants for the sprite-frame record parser
// no dependencies
package msp_pkg;

    // parse phases: four header bytes, then tile and attribute bytes
    typedef enum logic [2:0] {
        PH_X    = 3'd0,
        PH_Y    = 3'd1,
        PH_W    = 3'd2,
        PH_H    = 3'd3,
        PH_TILE = 3'd4,
        PH_ATTR = 3'd5
    } phase_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_VISIBLE     = 3'd1,
        KIND_EMPTY       = 3'd2,
        KIND_HDR_TRUNC   = 3'd3,
        KIND_BAD_SIZE    = 3'd4,
        KIND_CELLS_TRUNC = 3'd5,
        KIND_ATTR_TRUNC  = 3'd6
    } kind_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_HEIGHT = 8'd1;

    // byte codes
    localparam logic [7:0] EMPTY_CELL  = 8'hFF;
    localparam logic [7:0] MAX_DIM_RST = 8'hFF;
    localparam int unsigned ATTR_FLIP_H = 6;
    localparam int unsigned ATTR_FLIP_V = 7;

    // one result
    typedef struct packed {
        kind_t      kind;
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [7:0] width;
        logic [7:0] height;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] tile;
        logic [1:0] palette;
        logic       flip_h;
        logic       flip_v;
        logic       last;
    } result_t;

endpackage

/* rtl/metasprite_record_parser.sv */
// sprite-frame record parser: byte stream in, header and cell results out
// depends on msp_pkg and metasprite_record_parser_assert.svh
//
// usage
//   in channel: one stream byte per request (data_byte, final_byte set on the
//   last byte of the stream), valid/ready handshake
//   out channel: at most one result per byte - a header result on the height
//   byte, one result per cell on its last byte, or a coded error
//   cfg channel: cfg_index 0 writes max_width, 1 writes max_height, other
//   indexes are dropped; cfg_ready is always high
//   result: registered, so it appears on out_valid in the cycle after its byte is taken
//   throughput: one byte per cycle, set by the single phase update between
//   the input handshake and the result register
//   stall: the result register holds while out_ready is low; in_ready then
//   drops until the result is taken, and rises again in the cycle it leaves
//   reset: phase returns to the first header byte, held values clear, both
//   limits return to 255 and the error latch clears
//   after any error every further byte is taken and dropped until reset
module metasprite_record_parser
    import msp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // byte input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   final_byte,
    // results
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             record_kind,
    output logic signed [7:0]      origin_x,
    output logic signed [7:0]      origin_y,
    output logic [7:0]             frame_width,
    output logic [7:0]             frame_height,
    output logic [7:0]             cell_column,
    output logic [7:0]             cell_row,
    output logic [7:0]             tile_index,
    output logic [1:0]             palette_index,
    output logic                   flip_h,
    output logic                   flip_v,
    output logic                   last_of_frame,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

`include "metasprite_record_parser_assert.svh"

    phase_t     phase_reg, phase_next;
    logic [7:0] ox_reg, ox_next;
    logic [7:0] oy_reg, oy_next;
    logic [7:0] w_reg, w_next;
    logic [7:0] h_reg, h_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] tile_reg, tile_next;
    logic       err_reg, err_next;
    logic [7:0] max_w_reg, max_h_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg, res;
    logic       res_fire;

    logic       in_fire;
    logic       col_wrap;
    logic       last_cell;
    logic [7:0] col_inc;
    logic [7:0] row_inc;
    logic [7:0] adv_col;
    logic [7:0] adv_row;
    phase_t     adv_phase;
    logic       bad_size;
    logic       empty_byte;

    // handshakes
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // cell position stepping
    assign col_inc    = col_reg + 8'd1;
    assign row_inc    = row_reg + 8'd1;
    assign col_wrap   = (col_inc == w_reg);
    assign last_cell  = col_wrap && (row_inc == h_reg);
    assign adv_col    = col_wrap ? 8'd0 : col_inc;
    assign adv_row    = last_cell ? 8'd0 : (col_wrap ? row_inc : row_reg);
    assign adv_phase  = last_cell ? PH_X : PH_TILE;
    assign empty_byte = (data_byte == EMPTY_CELL);

    // size check on the height byte
    assign bad_size = (w_reg == 8'd0) || (data_byte == 8'd0) ||
                      (w_reg > max_w_reg) || (data_byte > max_h_reg);

    // next parse state
    always_comb
    begin
        phase_next = phase_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        tile_next  = tile_reg;
        err_next   = err_reg;
        if (in_fire && !err_reg)
        begin
            unique case (phase_reg) inside
                PH_X, PH_Y, PH_W:
                begin
                    if (phase_reg == PH_X)
                        ox_next = data_byte;
                    else if (phase_reg == PH_Y)
                        oy_next = data_byte;
                    else
                        w_next = data_byte;
                    if (final_byte)
                        err_next = 1'b1;
                    else
                        phase_next = phase_t'(phase_reg + 3'd1);
                end
                PH_H:
                begin
                    h_next   = data_byte;
                    col_next = 8'd0;
                    row_next = 8'd0;
                    if (bad_size || final_byte)
                        err_next = 1'b1;
                    else
                        phase_next = PH_TILE;
                end
                PH_TILE:
                begin
                    if (empty_byte)
                    begin
                        col_next   = adv_col;
                        row_next   = adv_row;
                        phase_next = adv_phase;
                        if (final_byte && !last_cell)
                            err_next = 1'b1;
                    end
                    else
                    begin
                        tile_next = data_byte;
                        if (final_byte)
                            err_next = 1'b1;
                        else
                            phase_next = PH_ATTR;
                    end
                end
                PH_ATTR:
                begin
                    col_next   = adv_col;
                    row_next   = adv_row;
                    phase_next = adv_phase;
                    if (final_byte && !last_cell)
                        err_next = 1'b1;
                end
                default:
                begin
                    phase_next = PH_X;
                end
            endcase
        end
    end

    // result for the byte being taken
    always_comb
    begin
        res_fire    = 1'b0;
        res         = '0;
        res.kind    = KIND_HEADER;
        res.origin_x = ox_reg;
        res.origin_y = oy_reg;
        res.width    = w_reg;
        res.height   = h_reg;
        res.column   = col_reg;
        res.row      = row_reg;
        if (in_fire && !err_reg)
        begin
            unique case (phase_reg) inside
                PH_X, PH_Y, PH_W:
                begin
                    if (final_byte)
                    begin
                        res_fire = 1'b1;
                        res      = '0;
                        res.kind = KIND_HDR_TRUNC;
                    end
                end
                PH_H:
                begin
                    res_fire   = 1'b1;
                    res.height = data_byte;
                    res.column = 8'd0;
                    res.row    = 8'd0;
                    if (bad_size)
                        res.kind = KIND_BAD_SIZE;
                    else if (final_byte)
                        res.kind = KIND_CELLS_TRUNC;
                    else
                        res.kind = KIND_HEADER;
                end
                PH_TILE:
                begin
                    if (empty_byte)
                    begin
                        res_fire = 1'b1;
                        if (final_byte && !last_cell)
                        begin
                            res.kind   = KIND_CELLS_TRUNC;
                            res.column = adv_col;
                            res.row    = adv_row;
                        end
                        else
                        begin
                            res.kind = KIND_EMPTY;
                            res.last = last_cell;
                        end
                    end
                    else if (final_byte)
                    begin
                        res_fire = 1'b1;
                        res.kind = KIND_ATTR_TRUNC;
                        res.tile = data_byte;
                    end
                end
                PH_ATTR:
                begin
                    res_fire = 1'b1;
                    if (final_byte && !last_cell)
                    begin
                        res.kind   = KIND_CELLS_TRUNC;
                        res.column = adv_col;
                        res.row    = adv_row;
                    end
                    else
                    begin
                        res.kind    = KIND_VISIBLE;
                        res.tile    = tile_reg;
                        res.palette = data_byte[1:0];
                        res.flip_h  = data_byte[ATTR_FLIP_H];
                        res.flip_v  = data_byte[ATTR_FLIP_V];
                        res.last    = last_cell;
                    end
                end
                default:
                begin
                    res_fire = 1'b0;
                end
            endcase
        end
    end

    // result register occupancy
    always_comb
    begin
        if (res_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_X;
            ox_reg        <= 8'd0;
            oy_reg        <= 8'd0;
            w_reg         <= 8'd0;
            h_reg         <= 8'd0;
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            tile_reg      <= 8'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            tile_reg      <= tile_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with each new result
    always_ff @(posedge clk)
    begin
        if (res_fire)
            result_reg <= res;
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_w_reg <= MAX_DIM_RST;
            max_h_reg <= MAX_DIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_WIDTH:  max_w_reg <= cfg_data;
                REG_MAX_HEIGHT: max_h_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // output ports
    assign out_valid     = out_valid_reg;
    assign record_kind   = result_reg.kind;
    assign origin_x      = $signed(result_reg.origin_x);
    assign origin_y      = $signed(result_reg.origin_y);
    assign frame_width   = result_reg.width;
    assign frame_height  = result_reg.height;
    assign cell_column   = result_reg.column;
    assign cell_row      = result_reg.row;
    assign tile_index    = result_reg.tile;
    assign palette_index = result_reg.palette;
    assign flip_h        = result_reg.flip_h;
    assign flip_v        = result_reg.flip_v;
    assign last_of_frame = result_reg.last;

    // checks
    `MSP_ASSERT_NEXT(a_no_result_after_error,
        err_reg && (!out_valid_reg || out_ready), !out_valid_reg)
    `MSP_ASSERT_NOW(a_cell_phase_dims_nonzero,
        phase_reg == PH_TILE || phase_reg == PH_ATTR,
        w_reg != 8'd0 && h_reg != 8'd0)
    `MSP_ASSERT_NOW(a_cell_pos_in_frame,
        phase_reg == PH_TILE || phase_reg == PH_ATTR,
        col_reg < w_reg && row_reg < h_reg)
    `MSP_ASSERT_NOW(a_header_at_origin,
        out_valid_reg && result_reg.kind == KIND_HEADER,
        result_reg.column == 8'd0 && result_reg.row == 8'd0 && !result_reg.last)

endmodule

/* tb/metasprite_record_parser_test.sv */
// self-checking testbench for the sprite-frame record parser
// depends on msp_pkg and the metasprite_record_parser rtl; bytes in, records checked out
module metasprite_record_parser_test
    import msp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int ITEM_TARGET   = 800;
    localparam int SIDE_CAP      = 8;

    typedef enum int {
        FAULT_CUT_HEADER,
        FAULT_BAD_DIMENSION,
        FAULT_CUT_CELLS,
        FAULT_CUT_ATTRIBUTE
    } stream_fault_t;

    typedef enum int {
        DIM_ZERO_WIDTH,
        DIM_ZERO_HEIGHT,
        DIM_WIDE,
        DIM_TALL
    } dim_fault_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             data_byte;
    logic                   final_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             record_kind;
    logic signed [7:0]      origin_x;
    logic signed [7:0]      origin_y;
    logic [7:0]             frame_width;
    logic [7:0]             frame_height;
    logic [7:0]             cell_column;
    logic [7:0]             cell_row;
    logic [7:0]             tile_index;
    logic [1:0]             palette_index;
    logic                   flip_h;
    logic                   flip_v;
    logic                   last_of_frame;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // parser state as the testbench sees it
    phase_t     parse_state;
    logic [7:0] frame_x;
    logic [7:0] frame_y;
    logic [7:0] frame_w;
    logic [7:0] frame_h;
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    logic [7:0] pending_tile;
    bit         stream_dead;
    logic [7:0] limit_w;
    logic [7:0] limit_h;

    result_t       due_records[$];
    int            failures       = 0;
    int            bytes_accepted = 0;
    int            results_checked = 0;
    int            frames_sent    = 0;
    bit            no_gaps        = 1'b0;
    stream_fault_t closing_fault;

    metasprite_record_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_kind   (record_kind),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .frame_width   (frame_width),
        .frame_height  (frame_height),
        .cell_column   (cell_column),
        .cell_row      (cell_row),
        .tile_index    (tile_index),
        .palette_index (palette_index),
        .flip_h        (flip_h),
        .flip_v        (flip_v),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // parser prediction
    // ---------------------------------------------------------------

    function automatic void reset_parser_state();
        parse_state  = PH_X;
        frame_x      = '0;
        frame_y      = '0;
        frame_w      = '0;
        frame_h      = '0;
        cur_col      = '0;
        cur_row      = '0;
        pending_tile = '0;
        stream_dead  = 1'b0;
        limit_w      = MAX_DIM_RST;
        limit_h      = MAX_DIM_RST;
    endfunction

    function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] index, logic [7:0] value);
        case (index)
            REG_MAX_WIDTH:  limit_w = value;
            REG_MAX_HEIGHT: limit_h = value;
            default: ;
        endcase
    endfunction

    // queue the next record the parser owes
    function automatic void add_due_record(result_t r);
        due_records.insert(due_records.size(), r);
    endfunction

    // header values and cell position, everything else cleared
    function automatic result_t frame_record(kind_t kind);
        result_t r;
        r          = '0;
        r.kind     = kind;
        r.origin_x = frame_x;
        r.origin_y = frame_y;
        r.width    = frame_w;
        r.height   = frame_h;
        r.column   = cur_col;
        r.row      = cur_row;
        return r;
    endfunction

    function automatic bit on_last_cell();
        return (8'(cur_col + 8'd1) == frame_w) && (8'(cur_row + 8'd1) == frame_h);
    endfunction

    // step to the next cell, back to the header after the final one
    function automatic void step_cell_position();
        if (on_last_cell())
        begin
            cur_col     = '0;
            cur_row     = '0;
            parse_state = PH_X;
        end
        else if (8'(cur_col + 8'd1) == frame_w)
        begin
            cur_col     = '0;
            cur_row     = 8'(cur_row + 8'd1);
            parse_state = PH_TILE;
        end
        else
        begin
            cur_col     = 8'(cur_col + 8'd1);
            parse_state = PH_TILE;
        end
    endfunction

    // work out the record, if any, that one accepted byte produces
    function automatic void parse_byte(logic [7:0] value, logic last_byte);
        result_t r;
        bit      last;
        if (stream_dead)
            return;
        case (parse_state) inside
            PH_X, PH_Y, PH_W:
            begin
                if (parse_state == PH_X)
                    frame_x = value;
                else if (parse_state == PH_Y)
                    frame_y = value;
                else
                    frame_w = value;
                if (last_byte)
                begin
                    stream_dead = 1'b1;
                    r           = '0;
                    r.kind      = KIND_HDR_TRUNC;
                    add_due_record(r);
                end
                else
                    parse_state = phase_t'(parse_state + 3'd1);
            end
            PH_H:
            begin
                frame_h = value;
                cur_col = '0;
                cur_row = '0;
                // size check wins over a cut stream
                if (frame_w == 0 || frame_h == 0 || frame_w > limit_w || frame_h > limit_h)
                begin
                    stream_dead = 1'b1;
                    add_due_record(frame_record(KIND_BAD_SIZE));
                end
                else if (last_byte)
                begin
                    stream_dead = 1'b1;
                    add_due_record(frame_record(KIND_CELLS_TRUNC));
                end
                else
                begin
                    parse_state = PH_TILE;
                    add_due_record(frame_record(KIND_HEADER));
                end
            end
            PH_TILE:
            begin
                if (value == EMPTY_CELL)
                begin
                    last = on_last_cell();
                    if (last_byte && !last)
                    begin
                        step_cell_position();
                        stream_dead = 1'b1;
                        add_due_record(frame_record(KIND_CELLS_TRUNC));
                    end
                    else
                    begin
                        r      = frame_record(KIND_EMPTY);
                        r.last = last;
                        add_due_record(r);
                        step_cell_position();
                    end
                end
                else
                begin
                    pending_tile = value;
                    if (last_byte)
                    begin
                        stream_dead = 1'b1;
                        r           = frame_record(KIND_ATTR_TRUNC);
                        r.tile      = pending_tile;
                        add_due_record(r);
                    end
                    else
                        parse_state = PH_ATTR;
                end
            end
            PH_ATTR:
            begin
                last = on_last_cell();
                if (last_byte && !last)
                begin
                    step_cell_position();
                    stream_dead = 1'b1;
                    add_due_record(frame_record(KIND_CELLS_TRUNC));
                end
                else
                begin
                    r         = frame_record(KIND_VISIBLE);
                    r.tile    = pending_tile;
                    r.palette = value[1:0];
                    r.flip_h  = value[ATTR_FLIP_H];
                    r.flip_v  = value[ATTR_FLIP_V];
                    r.last    = last;
                    add_due_record(r);
                    step_cell_position();
                end
            end
            default:
                parse_state = PH_X;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // request driving
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // one stream byte; valid stays up when the next request follows at once
    task automatic send_byte(input logic [7:0] value, input logic last_byte);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        final_byte <= last_byte;
        do @(posedge clk); while (in_ready !== 1'b1);
        parse_byte(value, last_byte);
        bytes_accepted++;
    endtask

    // stop sending and let every due record come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_reg_write(index, value);
    endtask

    // both limits plus a write to an unused index, only once every due record has come out
    task automatic set_limits(input logic [7:0] width_limit, input logic [7:0] height_limit);
        logic [CFG_INDEX_W-1:0] stray_index;
        stray_index = REG_MAX_HEIGHT + CFG_INDEX_W'(1 + $urandom_range(0, 253));
        drain_results();
        write_reg(REG_MAX_WIDTH, width_limit);
        write_reg(REG_MAX_HEIGHT, height_limit);
        write_reg(stray_index, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header(input int w, input int h, input logic last_byte);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'(w), 1'b0);
        send_byte(8'(h), last_byte);
    endtask

    task automatic send_cell(input bit empty, input logic last_byte);
        if (empty)
            send_byte(EMPTY_CELL, last_byte);
        else
        begin
            send_byte(8'($urandom_range(0, 254)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), last_byte);
        end
    endtask

    // whole frame, sometimes closing the stream on its final cell
    task automatic send_frame(input int w, input int h, input int empty_pct);
        int cells;
        cells   = w * h;
        no_gaps = ($urandom_range(0, 3) == 0);
        send_header(w, h, 1'b0);
        for (int i = 0; i < cells; i++)
            send_cell($urandom_range(0, 99) < empty_pct,
                      (i == cells - 1) && ($urandom_range(0, 3) == 0));
        frames_sent++;
    endtask

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 8'd1;
            1:       return MAX_DIM_RST;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // offset extremes, tile and attribute extremes, empty cells, stream end on a frame end
    task automatic test_directed_cells();
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(EMPTY_CELL, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b0);

        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(EMPTY_CELL, 1'b1);
        frames_sent += 3;
    endtask

    // smallest limits, then the widest and the tallest frames allowed
    task automatic test_limit_extremes();
        set_limits(8'd1, 8'd1);
        repeat (4) send_frame(1, 1, 50);
        set_limits(MAX_DIM_RST, MAX_DIM_RST);
        send_frame(255, 1, 90);
        send_frame(1, 255, 90);
    endtask

    // small frames with random content under changing limits
    task automatic test_random_frames();
        int w_cap;
        int h_cap;
        while (bytes_accepted < ITEM_TARGET)
        begin
            if (frames_sent % 3 == 0)
                set_limits(pick_limit(), pick_limit());
            w_cap = (limit_w < SIDE_CAP) ? limit_w : SIDE_CAP;
            h_cap = (limit_h < SIDE_CAP) ? limit_h : SIDE_CAP;
            send_frame($urandom_range(1, w_cap), $urandom_range(1, h_cap),
                       $urandom_range(10, 70));
        end
    endtask

    // one fault closes the run, since the parser stays dead until reset
    task automatic test_stream_fault();
        dim_fault_t dim_fault;
        int         cut;
        int         w;
        int         h;
        int         lim;
        set_limits(MAX_DIM_RST, MAX_DIM_RST);
        no_gaps       = ($urandom_range(0, 3) == 0);
        closing_fault = stream_fault_t'($urandom_range(0, 3));
        case (closing_fault)
            FAULT_CUT_HEADER:
            begin
                cut = $urandom_range(0, 2);
                for (int i = 0; i <= cut; i++)
                    send_byte(8'($urandom_range(0, 255)), i == cut);
            end
            FAULT_BAD_DIMENSION:
            begin
                dim_fault = dim_fault_t'($urandom_range(0, 3));
                lim       = $urandom_range(1, 254);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                case (dim_fault)
                    DIM_ZERO_WIDTH:
                    begin
                        send_byte(8'd0, 1'b0);
                        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    end
                    DIM_ZERO_HEIGHT:
                    begin
                        send_byte(8'($urandom_range(1, 255)), 1'b0);
                        send_byte(8'd0, 1'($urandom_range(0, 1)));
                    end
                    DIM_WIDE:
                    begin
                        // the new limit only counts from the height byte on
                        send_byte(8'($urandom_range(lim + 1, 255)), 1'b0);
                        set_limits(8'(lim), MAX_DIM_RST);
                        send_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
                    end
                    default:
                    begin
                        send_byte(8'($urandom_range(1, 255)), 1'b0);
                        set_limits(MAX_DIM_RST, 8'(lim));
                        send_byte(8'($urandom_range(lim + 1, 255)), 1'($urandom_range(0, 1)));
                    end
                endcase
            end
            FAULT_CUT_CELLS:
            begin
                w = $urandom_range(2, 6);
                h = $urandom_range(1, 6);
                if ($urandom_range(0, 3) == 0)
                    send_header(w, h, 1'b1);
                else
                begin
                    send_header(w, h, 1'b0);
                    cut = $urandom_range(0, w * h - 2);
                    for (int i = 0; i <= cut; i++)
                        send_cell(1'($urandom_range(0, 1)), i == cut);
                end
            end
            default:
            begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 6);
                send_header(w, h, 1'b0);
                cut = $urandom_range(0, w * h - 1);
                for (int i = 0; i < cut; i++)
                    send_cell(1'($urandom_range(0, 1)), 1'b0);
                send_byte(8'($urandom_range(0, 254)), 1'b1);
            end
        endcase
        frames_sent++;
        // the dead parser must swallow these silently
        repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // compare each taken result with the oldest due record
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (due_records.size() == 0)
            begin
                $display("%0t ns: unexpected result, kind %0d", $time, record_kind);
                failures++;
            end
            else
            begin
                want = due_records.pop_front();
                check_field("record_kind", 8'(want.kind), 8'(record_kind));
                check_field("origin_x", want.origin_x, origin_x);
                check_field("origin_y", want.origin_y, origin_y);
                check_field("frame_width", want.width, frame_width);
                check_field("frame_height", want.height, frame_height);
                check_field("cell_column", want.column, cell_column);
                check_field("cell_row", want.row, cell_row);
                check_field("tile_index", want.tile, tile_index);
                check_field("palette_index", 8'(want.palette), 8'(palette_index));
                check_field("flip_h", 8'(want.flip_h), 8'(flip_h));
                check_field("flip_v", 8'(want.flip_v), 8'(flip_v));
                check_field("last_of_frame", 8'(want.last), 8'(last_of_frame));
                results_checked++;
            end
        end
    end

    // result side back-pressure, drawn per result
    initial
    begin : result_sink
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // give up when no request of any kind has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("metasprite_record_parser_test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_byte  <= '0;
        final_byte <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        reset_parser_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cells();
        test_limit_extremes();
        test_random_frames();
        test_stream_fault();
        drain_results();

        $display("covered %0d stream bytes over %0d frames, %0d results checked",
                 bytes_accepted, frames_sent, results_checked);
        $display("stream closed by %s, final limits %0d x %0d",
                 closing_fault.name(), limit_w, limit_h);
        if (failures == 0)
            $display("metasprite_record_parser_test passed");
        else
            $display("metasprite_record_parser_test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/msp_pkg.sv
rtl/metasprite_record_parser.sv
tb/metasprite_record_parser_test.sv
